FILE: design/deque_push_pop_list_assert.svh
// ----------------------------------------------------------------------------
// deque_push_pop_list_assert
// assertion macros used by the deque top level
// ----------------------------------------------------------------------------
`ifndef DEQUE_PUSH_POP_LIST_ASSERT_SVH
`define DEQUE_PUSH_POP_LIST_ASSERT_SVH

// same-cycle implication, reset disables the check
`define DQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// next-cycle implication, reset disables the check
`define DQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

FILE: design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DATA_W    = 32;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int FILL_W    = 7;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_LIST       = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic op;
		logic list_load;
		logic list_step;
	} dq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic list_end;
	} dq_stat_t;

endpackage

FILE: design/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// controller: accepts commands and sequences list output
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [dq_pkg::ACT_W-1:0] action,
	input  dq_pkg::dq_stat_t         stat,
	output dq_pkg::dq_cmd_t          cmd,
	output logic                     busy
);
	import dq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (action == ACT_LIST && !stat.empty) begin
						cmd.list_load = 1'b1;
						state_d       = S_LIST;
					end else begin
						cmd.op = 1'b1;
					end
				end
			end
			S_LIST: begin
				busy          = 1'b1;
				cmd.list_step = 1'b1;
				if (stat.list_end) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/dq_data.sv
// ----------------------------------------------------------------------------
// dq_data
// datapath: slot memory, ring pointers and result registers
// ----------------------------------------------------------------------------
module dq_data #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dq_pkg::dq_cmd_t                  cmd,
	input  logic [dq_pkg::ACT_W-1:0]         action,
	input  logic signed [dq_pkg::DATA_W-1:0] value,
	output dq_pkg::dq_stat_t                 stat,
	output logic                             valid,
	output logic signed [dq_pkg::DATA_W-1:0] item,
	output logic [dq_pkg::STAT_W-1:0]        status,
	output logic [dq_pkg::FILL_W-1:0]        fill,
	output logic                             last
);
	import dq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);
	localparam logic [OW:0]   DEPTH_S  = (OW + 1)'(DEPTH);

	logic [DATA_W-1:0] mem [DEPTH];

	logic [IW-1:0]     front_q;
	logic [OW-1:0]     occ_q;
	logic [IW-1:0]     rd_ptr_q;
	logic [OW-1:0]     cnt_q;
	logic              valid_q;
	logic [DATA_W-1:0] item_q;
	logic [STAT_W-1:0] status_q;
	logic [OW-1:0]     fill_q;
	logic              last_q;

	logic          is_push;
	logic          is_pop;
	logic          full;
	logic          empty;
	logic [IW-1:0] front_dec;
	logic [IW-1:0] front_inc;
	logic [IW-1:0] rd_inc;
	logic [OW:0]   back_sum;
	logic [IW-1:0] back_idx;
	logic          list_end;

	assign is_push   = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK);
	assign is_pop    = (action == ACT_POP_FRONT) || (action == ACT_POP_BACK);
	assign full      = (occ_q == FULL_OCC);
	assign empty     = (occ_q == '0);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - IW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + IW'(1);
	assign rd_inc    = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IW'(1);
	assign back_sum  = (OW + 1)'(front_q) + (OW + 1)'(occ_q);
	assign back_idx  = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);
	assign list_end  = (cnt_q == occ_q - OW'(1));

	assign stat.empty    = empty;
	assign stat.list_end = list_end;

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q   <= '0;
		end else if (cmd.op) begin
			if (is_push && !full) begin
				occ_q <= occ_q + OW'(1);
				if (action == ACT_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end else if (is_pop && !empty) begin
				occ_q <= occ_q - OW'(1);
				if (action == ACT_POP_FRONT) begin
					front_q <= front_inc;
				end
			end
		end
	end

	// slot memory write
	always_ff @(posedge clk) begin
		if (cmd.op && is_push && !full) begin
			if (action == ACT_PUSH_FRONT) begin
				mem[front_dec] <= value;
			end else begin
				mem[back_idx] <= value;
			end
		end
	end

	// list walk
	always_ff @(posedge clk) begin
		if (cmd.list_load) begin
			rd_ptr_q <= front_q;
			cnt_q    <= '0;
		end else if (cmd.list_step) begin
			rd_ptr_q <= rd_inc;
			cnt_q    <= cnt_q + OW'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.list_step || (cmd.op && (is_push || is_pop || action == ACT_LIST));
		end
	end

	// result word, item read straight from the slot memory
	always_ff @(posedge clk) begin
		if (cmd.list_step) begin
			item_q   <= mem[rd_ptr_q];
			status_q <= ST_OK;
			fill_q   <= occ_q;
			last_q   <= list_end;
		end else begin
			item_q <= '0;
			last_q <= 1'b1;
			if (is_push) begin
				status_q <= full ? ST_FULL : ST_OK;
				fill_q   <= full ? occ_q : occ_q + OW'(1);
			end else if (is_pop && !empty) begin
				status_q <= ST_OK;
				fill_q   <= occ_q - OW'(1);
			end else begin
				status_q <= ST_EMPTY;
				fill_q   <= '0;
			end
		end
	end

	assign valid  = valid_q;
	assign item   = item_q;
	assign status = status_q;
	assign fill   = FILL_W'(fill_q);
	assign last   = last_q;

endmodule

FILE: design/deque_push_pop_list.sv
// ----------------------------------------------------------------------------
// deque_push_pop_list
// double-ended queue of signed 32-bit words held in a ring of DEPTH slots
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  command   start / busy     action, value
//  result    valid (strobe)   item, status, fill, last
//
//  push and pop: busy stays low, the status word appears on the next cycle,
//  so one command per cycle while no list is running; unused codes give no word
//  list: busy while it walks the stored words, one word per cycle read from
//  the slot memory port; an empty list answers with one status word
//  reset clears the ring pointers; no clearing pass, ready right after reset
//  results are never stalled: valid marks each word for exactly one cycle
// ----------------------------------------------------------------------------
module deque_push_pop_list #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [dq_pkg::ACT_W-1:0]         action,
	input  logic signed [dq_pkg::DATA_W-1:0] value,
	output logic                             valid,
	output logic signed [dq_pkg::DATA_W-1:0] item,
	output logic [dq_pkg::STAT_W-1:0]        status,
	output logic [dq_pkg::FILL_W-1:0]        fill,
	output logic                             last
);
	import dq_pkg::*;

	dq_cmd_t  cmd;
	dq_stat_t stat;

	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dq_data #(
		.DEPTH (DEPTH)
	) u_data (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.action (action),
		.value  (value),
		.stat   (stat),
		.valid  (valid),
		.item   (item),
		.status (status),
		.fill   (fill),
		.last   (last)
	);

`include "deque_push_pop_list_assert.svh"

	`DQ_ASSERT_IMP(a_busy_holds_off, busy, !cmd.op && !cmd.list_load)
	`DQ_ASSERT_NXT(a_step_strobes, cmd.list_step, valid)
	`DQ_ASSERT_IMP(a_flag_is_last, valid && (status != ST_OK), last)
	`DQ_ASSERT_IMP(a_fill_bound, valid, fill <= FILL_W'(DEPTH))

endmodule
